@@ rtl/msm_pkg.sv @@
// ---------------------------------------------------------------------------
// msm_pkg: shared types and constants of the saturating stream mixer
// Action codes, sequencer states, sample limits and the accumulator control.
// ---------------------------------------------------------------------------
package msm_pkg;

    localparam int SAMPLE_W = 16;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_EMIT  = 2'd1,
        ACT_OPEN  = 2'd2,
        ACT_CLOSE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MIX_RD,
        ST_MIX_ADD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctrl;

endpackage

@@ rtl/multi_stream_saturating_mixer.sv @@
// ---------------------------------------------------------------------------
// multi_stream_saturating_mixer: saturating mixer of several sample streams
// Per-slot FIFOs in one shared memory, mixed by a sequenced accumulator.
// ---------------------------------------------------------------------------
// Input stream: tuser carries the action (push, emit, open, close), tdata the
// slot and the sample. Output stream: tdata carries the mixed sample, tlast
// marks the last sample of each frame of FRAME_SAMPLES samples.
// Push, open and close are accepted in ST_IDLE and carried out in ST_EXEC,
// after which the next transaction is accepted.
// An emit walks the slots in ascending order through one shared saturating
// adder: one step per empty or closed slot, two per slot with data (memory
// read, then add), after the accepting state. After the last slot step,
// ST_EMIT loads the mixed sample into the output register once it is free.
// A held result does not stop push, open or close transactions; a further
// emit waits at its output step until the receiver takes the previous result.
// Reset closes every slot, empties the FIFOs and restarts the frame count;
// the sample memory itself is not cleared and needs no sweep.
// ---------------------------------------------------------------------------
module multi_stream_saturating_mixer #(
    parameter int NUM_STREAMS   = 8,
    parameter int FIFO_DEPTH    = 4096,
    parameter int FRAME_SAMPLES = 960
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // slot [2:0], sample [18:3], zeros above
    input  logic [1:0]  i_s_axis_tuser,   // action [1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // mixed_sample [15:0]
    output logic        o_m_axis_tlast
);

    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int AW = SW + PW;
    localparam int MEM_DEPTH = NUM_STREAMS * (2 ** PW);
    localparam int FW = (FRAME_SAMPLES > 1) ? $clog2(FRAME_SAMPLES) : 1;

    msm_pkg::t_state  r_state, n_state;
    msm_pkg::t_action r_act, n_act;
    logic [SW-1:0]    r_idx, n_idx;
    logic             r_slot_ok, n_slot_ok;
    logic [15:0]      r_sample, n_sample;
    logic [FW-1:0]    r_frame, n_frame;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_out_data, n_out_data;
    logic             r_out_last, n_out_last;

    logic             r_open [NUM_STREAMS];
    logic [PW-1:0]    r_head [NUM_STREAMS];
    logic [CW-1:0]    r_fill [NUM_STREAMS];

    logic             cur_open;
    logic [PW-1:0]    cur_head;
    logic [CW-1:0]    cur_fill;
    logic             cur_full;
    logic [PW:0]      head_sum;
    logic [PW-1:0]    head_next;
    logic [PW:0]      tail_sum;
    logic [PW-1:0]    push_pos;
    logic             last_idx;
    logic             frame_end;
    logic             accept;
    logic             tbl_push, tbl_pop, tbl_open, tbl_close;
    logic             mem_re;
    logic [15:0]      mem_rdata;
    logic signed [15:0] acc;
    msm_pkg::t_acc_ctrl acc_ctrl;

    assign cur_open = r_open[r_idx];
    assign cur_head = r_head[r_idx];
    assign cur_fill = r_fill[r_idx];
    assign cur_full = (cur_fill == CW'(FIFO_DEPTH));

    always_comb begin
        head_sum  = {1'b0, cur_head} + (PW+1)'(1);
        head_next = (head_sum == (PW+1)'(FIFO_DEPTH)) ? '0 : head_sum[PW-1:0];
        tail_sum  = (PW+1)'(cur_head) + (PW+1)'(cur_fill);
        if (tail_sum >= (PW+1)'(FIFO_DEPTH)) begin
            tail_sum = tail_sum - (PW+1)'(FIFO_DEPTH);
        end
        // A full FIFO drops its oldest sample, whose place takes the new one.
        push_pos = cur_full ? cur_head : tail_sum[PW-1:0];
    end

    assign last_idx  = (32'(r_idx) == NUM_STREAMS - 1);
    assign frame_end = (32'(r_frame) == FRAME_SAMPLES - 1);
    assign accept    = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_idx       = r_idx;
        n_slot_ok   = r_slot_ok;
        n_sample    = r_sample;
        n_frame     = r_frame;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_s_axis_tready = 1'b0;
        acc_ctrl    = '0;
        mem_re      = 1'b0;
        tbl_push    = 1'b0;
        tbl_pop     = 1'b0;
        tbl_open    = 1'b0;
        tbl_close   = 1'b0;
        unique case (r_state)
            msm_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_act     = msm_pkg::t_action'(i_s_axis_tuser);
                    n_sample  = i_s_axis_tdata[18:3];
                    n_slot_ok = (32'(i_s_axis_tdata[2:0]) < NUM_STREAMS);
                    n_idx     = SW'(i_s_axis_tdata[2:0]);
                    if (msm_pkg::t_action'(i_s_axis_tuser) == msm_pkg::ACT_EMIT) begin
                        n_idx          = '0;
                        acc_ctrl.clear = 1'b1;
                        n_state        = msm_pkg::ST_MIX_RD;
                    end else begin
                        n_state = msm_pkg::ST_EXEC;
                    end
                end
            end
            msm_pkg::ST_EXEC: begin
                n_state = msm_pkg::ST_IDLE;
                if (r_slot_ok) begin
                    unique case (r_act)
                        msm_pkg::ACT_PUSH:  tbl_push  = cur_open;
                        msm_pkg::ACT_OPEN:  tbl_open  = !cur_open;
                        msm_pkg::ACT_CLOSE: tbl_close = 1'b1;
                        msm_pkg::ACT_EMIT:  tbl_close = 1'b0;
                    endcase
                end
            end
            msm_pkg::ST_MIX_RD: begin
                if (cur_open && (cur_fill != '0)) begin
                    mem_re  = 1'b1;
                    n_state = msm_pkg::ST_MIX_ADD;
                end else if (last_idx) begin
                    n_state = msm_pkg::ST_EMIT;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            msm_pkg::ST_MIX_ADD: begin
                acc_ctrl.add = 1'b1;
                tbl_pop      = 1'b1;
                if (last_idx) begin
                    n_state = msm_pkg::ST_EMIT;
                end else begin
                    n_idx   = r_idx + SW'(1);
                    n_state = msm_pkg::ST_MIX_RD;
                end
            end
            msm_pkg::ST_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = acc;
                    n_out_last  = frame_end;
                    n_frame     = frame_end ? '0 : r_frame + FW'(1);
                    n_state     = msm_pkg::ST_IDLE;
                end
            end
            default: n_state = msm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msm_pkg::ST_IDLE;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame     <= n_frame;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_idx      <= n_idx;
        r_slot_ok  <= n_slot_ok;
        r_sample   <= n_sample;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STREAMS; s++) begin
                r_open[s] <= 1'b0;
                r_head[s] <= '0;
                r_fill[s] <= '0;
            end
        end else if (tbl_open || tbl_close) begin
            r_open[r_idx] <= tbl_open;
            r_head[r_idx] <= '0;
            r_fill[r_idx] <= '0;
        end else if (tbl_push) begin
            if (cur_full) begin
                r_head[r_idx] <= head_next;
            end else begin
                r_fill[r_idx] <= cur_fill + CW'(1);
            end
        end else if (tbl_pop) begin
            r_head[r_idx] <= head_next;
            r_fill[r_idx] <= cur_fill - CW'(1);
        end
    end

    msm_store #(
        .AW    (AW),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (tbl_push),
        .i_waddr ({r_idx, push_pos}),
        .i_wdata (r_sample),
        .i_re    (mem_re),
        .i_raddr ({r_idx, cur_head}),
        .o_rdata (mem_rdata)
    );

    msm_sat_acc u_acc (
        .i_clk     (i_clk),
        .i_ctrl    (acc_ctrl),
        .i_operand (mem_rdata),
        .o_acc     (acc)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule

@@ rtl/msm_store.sv @@
// ---------------------------------------------------------------------------
// msm_store: sample memory shared by all stream FIFOs
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module msm_store #(
    parameter int AW    = 15,
    parameter int DEPTH = 32768
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [msm_pkg::SAMPLE_W-1:0]  i_wdata,
    input  logic                          i_re,
    input  logic [AW-1:0]                 i_raddr,
    output logic [msm_pkg::SAMPLE_W-1:0]  o_rdata
);

    logic [msm_pkg::SAMPLE_W-1:0] r_mem [DEPTH];
    logic [msm_pkg::SAMPLE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/msm_sat_acc.sv @@
// ---------------------------------------------------------------------------
// msm_sat_acc: saturating accumulator
// Adds one signed sample per step and clamps the running sum to 16 bits.
// ---------------------------------------------------------------------------
module msm_sat_acc (
    input  logic                                 i_clk,
    input  msm_pkg::t_acc_ctrl                   i_ctrl,
    input  logic signed [msm_pkg::SAMPLE_W-1:0]  i_operand,
    output logic signed [msm_pkg::SAMPLE_W-1:0]  o_acc
);

    logic signed [msm_pkg::SAMPLE_W-1:0] r_acc;
    logic signed [msm_pkg::SAMPLE_W-1:0] n_acc;
    logic signed [msm_pkg::SAMPLE_W:0]   sum;

    always_comb begin
        sum = {r_acc[msm_pkg::SAMPLE_W-1], r_acc}
            + {i_operand[msm_pkg::SAMPLE_W-1], i_operand};
        // The two top bits differ only when the sum has left the 16-bit range.
        if (sum[msm_pkg::SAMPLE_W] != sum[msm_pkg::SAMPLE_W-1]) begin
            n_acc = sum[msm_pkg::SAMPLE_W] ? msm_pkg::SAMPLE_MIN : msm_pkg::SAMPLE_MAX;
        end else begin
            n_acc = sum[msm_pkg::SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_acc <= '0;
        end else if (i_ctrl.add) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
